/* hw/rtl/ppoa_pkg.sv */
// Package for the pulse period and on-time averager.
// Holds field widths, the default window depth, the sum width helper and
// the pipeline stage-enable struct shared by the divider and the top level.
`default_nettype none

package ppoa_pkg;

  // Width of a timestamp, a window entry and an average
  localparam int DATA_W = 32;

  // Default number of entries in each sliding window
  localparam int WINDOW_DEF = 5;

  // Input tuser bit positions
  localparam int USER_RISE = 0;
  localparam int USER_FALL = 1;
  localparam int USER_W    = 2;

  // Output tdata width: two averages side by side
  localparam int OUT_DATA_W = 2 * DATA_W;

  // Running sum width: wide enough that WINDOW full-scale entries never wrap
  function automatic int sum_width(input int window);
    return DATA_W + $clog2(window);
  endfunction

  // Advance strobes for the three pipeline stages
  typedef struct packed {
    logic load;  // take a fresh window sum
    logic mul;   // form the reciprocal partial products
    logic fin;   // add the partial products and load the average
  } ppoa_stage_en_t;

endpackage

`default_nettype wire

/* hw/rtl/ppoa_cell.sv */
// One window entry of the averager's shift chain.
// Holds a 32-bit sample and takes its neighbor's value on a shift.
// Depends on ppoa_pkg for the data width.
`default_nettype none

module ppoa_cell (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         shift_en,
  input  wire logic [ppoa_pkg::DATA_W-1:0]  din,
  output logic      [ppoa_pkg::DATA_W-1:0]  dout
);

  logic [ppoa_pkg::DATA_W-1:0] value_r;
  logic [ppoa_pkg::DATA_W-1:0] value_nxt;

  // Take the neighbor's sample on a shift, hold otherwise
  always_comb begin
    value_nxt = shift_en ? din : value_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      value_r <= '0;
    end else begin
      value_r <= value_nxt;
    end
  end

  assign dout = value_r;

endmodule

`default_nettype wire

/* hw/rtl/ppoa_window.sv */
// Sliding window built as a chain of ppoa_cell entries plus a running sum.
// The newest sample enters at the top cell; cell 0 holds the oldest.
// Depends on ppoa_pkg and ppoa_cell.
`default_nettype none

module ppoa_window #(
  parameter int WINDOW = ppoa_pkg::WINDOW_DEF,
  parameter int SUM_W  = ppoa_pkg::sum_width(ppoa_pkg::WINDOW_DEF)
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         shift_en,
  input  wire logic [ppoa_pkg::DATA_W-1:0]  din,
  output logic      [SUM_W-1:0]             sum_nxt
);

  logic [ppoa_pkg::DATA_W-1:0] link [WINDOW+1];
  logic [SUM_W-1:0]            sum_r;

  // Newest sample feeds the top of the chain
  assign link[WINDOW] = din;

  // Each cell takes the value of the cell above it
  for (genvar i = 0; i < WINDOW; i++) begin : g_cell
    ppoa_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .shift_en (shift_en),
      .din      (link[i+1]),
      .dout     (link[i])
    );
  end

  // Add the incoming sample and drop the oldest one
  always_comb begin
    if (shift_en) begin
      sum_nxt = sum_r + SUM_W'(din) - SUM_W'(link[0]);
    end else begin
      sum_nxt = sum_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_r <= '0;
    end else begin
      sum_r <= sum_nxt;
    end
  end

endmodule

`default_nettype wire

/* hw/rtl/ppoa_div.sv */
// Pipelined divide of a window sum by the constant WINDOW.
// Multiplies by a rounded-up reciprocal in two half-width partial products,
// then adds and shifts. Depends on ppoa_pkg.
`default_nettype none

module ppoa_div #(
  parameter int WINDOW = ppoa_pkg::WINDOW_DEF,
  parameter int SUM_W  = ppoa_pkg::sum_width(ppoa_pkg::WINDOW_DEF)
) (
  input  wire logic                            clk,
  input  wire ppoa_pkg::ppoa_stage_en_t        stage_en,
  input  wire logic [SUM_W-1:0]                sum_in,
  output logic      [ppoa_pkg::DATA_W-1:0]     quot
);

  localparam int LOG_W  = $clog2(WINDOW);
  localparam int SHIFT  = SUM_W + LOG_W;
  localparam int MUL_W  = SUM_W + 1;
  localparam int LO_W   = SUM_W / 2;
  localparam int HI_W   = SUM_W - LO_W;
  localparam int LO_PW  = LO_W + MUL_W;
  localparam int HI_PW  = HI_W + MUL_W;
  localparam int TOT_W  = SUM_W + MUL_W;
  localparam logic [63:0] RECIP_FULL =
    ((64'd1 << SHIFT) + 64'(WINDOW) - 64'd1) / 64'(WINDOW);
  localparam logic [MUL_W-1:0] RECIP = RECIP_FULL[MUL_W-1:0];

  logic [SUM_W-1:0]            sum_r;
  logic [LO_PW-1:0]            lo_prod;
  logic [HI_PW-1:0]            hi_prod;
  logic [LO_PW-1:0]            lo_prod_r;
  logic [HI_PW-1:0]            hi_prod_r;
  logic [TOT_W-1:0]            total;
  logic [ppoa_pkg::DATA_W-1:0] quot_r;

  // Snapshot the sum as the request is accepted
  always_ff @(posedge clk) begin
    if (stage_en.load) begin
      sum_r <= sum_in;
    end
  end

  // Form the two partial products against the reciprocal
  always_comb begin
    lo_prod = LO_PW'(sum_r[LO_W-1:0]) * LO_PW'(RECIP);
    hi_prod = HI_PW'(sum_r[SUM_W-1:LO_W]) * HI_PW'(RECIP);
  end

  always_ff @(posedge clk) begin
    if (stage_en.mul) begin
      lo_prod_r <= lo_prod;
      hi_prod_r <= hi_prod;
    end
  end

  // Recombine and keep the quotient bits
  always_comb begin
    total = {hi_prod_r, {LO_W{1'b0}}} + TOT_W'(lo_prod_r);
  end

  always_ff @(posedge clk) begin
    if (stage_en.fin) begin
      quot_r <= total[SHIFT +: ppoa_pkg::DATA_W];
    end
  end

  assign quot = quot_r;

endmodule

`default_nettype wire

/* hw/rtl/pulse_period_ontime_averager.sv */
// Pulse period and on-time averager, top level.
// Input stream: one request per edge event. in_tuser carries the rise and
// fall flags, in_tdata the 32-bit millisecond timestamp. A rise after an
// earlier rise pushes the period into the period window; a fall after a
// rise pushes the on-time (zero when rise and fall share one event).
// Output stream: one result per request, in_tdata order kept, with the
// truncated mean of each WINDOW-entry window (zeros count until full).
// Throughput: one request per cycle while the output is not stalled;
// the windows and the last rise time update in the accept cycle, and
// the divide-by-WINDOW runs as a three stage pipeline (sum snapshot,
// partial products, add and shift). Each stage has its own valid bit,
// so bubbles close up while the output is stalled; in_tready drops
// only when all three stages hold results.
// Reset clears the windows, sums, last rise time, the rise-seen flag and
// all pipeline valid bits; out_tvalid is low after reset.
// Depends on ppoa_pkg, ppoa_cell, ppoa_window and ppoa_div.
`default_nettype none

module pulse_period_ontime_averager #(
  parameter int WINDOW = ppoa_pkg::WINDOW_DEF
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  // in_tdata: [31:0] time_stamp
  input  wire logic [ppoa_pkg::DATA_W-1:0]       in_tdata,
  // in_tuser: [0] rise_edge, [1] fall_edge
  input  wire logic [ppoa_pkg::USER_W-1:0]       in_tuser,
  input  wire logic                              in_tvalid,
  output logic                                   in_tready,
  // out_tdata: [31:0] average_period, [63:32] average_on_time
  output logic      [ppoa_pkg::OUT_DATA_W-1:0]   out_tdata,
  output logic                                   out_tvalid,
  input  wire logic                              out_tready
);

  localparam int SUM_W = ppoa_pkg::sum_width(WINDOW);

  logic                        rise;
  logic                        fall;
  logic [ppoa_pkg::DATA_W-1:0] now;
  logic [ppoa_pkg::DATA_W-1:0] last_rise_r;
  logic [ppoa_pkg::DATA_W-1:0] last_rise_nxt;
  logic                        rise_seen_r;
  logic                        rise_seen_nxt;
  logic [ppoa_pkg::DATA_W-1:0] since_rise;
  logic [ppoa_pkg::DATA_W-1:0] on_din;
  logic                        per_shift;
  logic                        on_shift;
  logic [SUM_W-1:0]            per_sum;
  logic [SUM_W-1:0]            on_sum;
  logic [ppoa_pkg::DATA_W-1:0] avg_period;
  logic [ppoa_pkg::DATA_W-1:0] avg_on_time;
  ppoa_pkg::ppoa_stage_en_t    stage_en;
  logic                        v1_r;
  logic                        v2_r;
  logic                        v3_r;
  logic                        v1_nxt;
  logic                        v2_nxt;
  logic                        v3_nxt;
  logic                        rdy1;
  logic                        rdy2;
  logic                        rdy3;

  // Unpack the request
  assign rise = in_tuser[ppoa_pkg::USER_RISE];
  assign fall = in_tuser[ppoa_pkg::USER_FALL];
  assign now  = in_tdata;

  // Stage readiness: a stage moves when it is empty or its successor moves
  always_comb begin
    rdy3 = !v3_r || out_tready;
    rdy2 = !v2_r || rdy3;
    rdy1 = !v1_r || rdy2;
  end

  assign in_tready = rdy1;

  // Stage advance strobes
  always_comb begin
    stage_en.load = in_tvalid && rdy1;
    stage_en.mul  = v1_r && rdy2;
    stage_en.fin  = v2_r && rdy3;
  end

  // Track which stages hold a result
  always_comb begin
    v1_nxt = stage_en.load || (v1_r && !stage_en.mul);
    v2_nxt = stage_en.mul  || (v2_r && !stage_en.fin);
    v3_nxt = stage_en.fin  || (v3_r && !out_tready);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      v1_r <= v1_nxt;
      v2_r <= v2_nxt;
      v3_r <= v3_nxt;
    end
  end

  // Edge decode: period on a repeated rise, on-time on a fall after a rise
  always_comb begin
    since_rise = now - last_rise_r;
    on_din     = rise ? '0 : since_rise;
    per_shift  = stage_en.load && rise && rise_seen_r;
    on_shift   = stage_en.load && fall && (rise || rise_seen_r);
  end

  // Update the last rise time and the rise-seen flag
  always_comb begin
    last_rise_nxt = last_rise_r;
    rise_seen_nxt = rise_seen_r;
    if (stage_en.load && rise) begin
      last_rise_nxt = now;
      rise_seen_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_rise_r <= '0;
      rise_seen_r <= 1'b0;
    end else begin
      last_rise_r <= last_rise_nxt;
      rise_seen_r <= rise_seen_nxt;
    end
  end

  // Period and on-time windows
  ppoa_window #(
    .WINDOW (WINDOW),
    .SUM_W  (SUM_W)
  ) u_per_win (
    .clk      (clk),
    .rst_n    (rst_n),
    .shift_en (per_shift),
    .din      (since_rise),
    .sum_nxt  (per_sum)
  );

  ppoa_window #(
    .WINDOW (WINDOW),
    .SUM_W  (SUM_W)
  ) u_on_win (
    .clk      (clk),
    .rst_n    (rst_n),
    .shift_en (on_shift),
    .din      (on_din),
    .sum_nxt  (on_sum)
  );

  // Divide each sum by the window depth
  ppoa_div #(
    .WINDOW (WINDOW),
    .SUM_W  (SUM_W)
  ) u_per_div (
    .clk      (clk),
    .stage_en (stage_en),
    .sum_in   (per_sum),
    .quot     (avg_period)
  );

  ppoa_div #(
    .WINDOW (WINDOW),
    .SUM_W  (SUM_W)
  ) u_on_div (
    .clk      (clk),
    .stage_en (stage_en),
    .sum_in   (on_sum),
    .quot     (avg_on_time)
  );

  // Drive the result channel
  assign out_tvalid = v3_r;
  assign out_tdata  = {avg_on_time, avg_period};

  // A free output stage must let the pipeline take a new request
  a_ready_chain: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_tvalid || out_tready) |-> in_tready)
    else $error("in_tready low while the output stage is free");

  // No period is recorded before a first rise
  a_period_after_rise: assert property (@(posedge clk) disable iff (!rst_n)
    per_shift |-> rise_seen_r)
    else $error("period window shifted before any rise");

  // A finishing divide always lands in the output register
  a_fin_lands: assert property (@(posedge clk) disable iff (!rst_n)
    stage_en.fin |=> out_tvalid)
    else $error("finished average did not reach the output");

endmodule

`default_nettype wire

/* tb/pulse_period_ontime_averager_test.sv */
// Testbench for pulse_period_ontime_averager: edge events in, window averages out.
// A local model of the rise time and the two windows predicts every result.
// Depends on ppoa_pkg and the averager RTL.
`timescale 1ns / 100ps

module pulse_period_ontime_averager_test;

  localparam int DATA_W     = ppoa_pkg::DATA_W;
  localparam int USER_W     = ppoa_pkg::USER_W;
  localparam int USER_RISE  = ppoa_pkg::USER_RISE;
  localparam int USER_FALL  = ppoa_pkg::USER_FALL;
  localparam int OUT_DATA_W = ppoa_pkg::OUT_DATA_W;

  localparam int WINDOW     = ppoa_pkg::WINDOW_DEF;
  localparam int IDLE_LIMIT = 5000;
  localparam int TAIL_WAIT  = 8;

  typedef logic [WINDOW-1:0][DATA_W-1:0] window_t;

  typedef struct packed {
    logic [DATA_W-1:0] on_time;
    logic [DATA_W-1:0] period;
  } averages_t;

  logic                  clk        = 1'b0;
  logic                  rst_n      = 1'b0;
  logic [DATA_W-1:0]     in_tdata   = '0;
  logic [USER_W-1:0]     in_tuser   = '0;
  logic                  in_tvalid  = 1'b0;
  logic                  in_tready;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;

  // Model of the block's state
  logic [DATA_W-1:0] model_last_rise = '0;
  logic              model_rise_seen = 1'b0;
  window_t           model_periods   = '0;
  window_t           model_on_times  = '0;

  averages_t pending_averages[$];

  int err_count       = 0;
  int events_sent     = 0;
  int results_checked = 0;
  int send_gap_pct    = 30;
  int sink_stall_pct  = 30;
  int stall_left      = 0;
  int idle_cycles     = 0;

  pulse_period_ontime_averager #(
    .WINDOW(WINDOW)
  ) u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .out_tdata (out_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready)
  );

  always #1 clk = ~clk;

  // Idle length: mostly short, now and then long
  function automatic int idle_length();
    if ($urandom_range(0, 99) < 80) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Drop the oldest entry and append a new one (index 0 oldest)
  function automatic window_t push_sample(window_t w, logic [DATA_W-1:0] v);
    for (int i = 0; i < WINDOW - 1; i++) w[i] = w[i + 1];
    w[WINDOW-1] = v;
    return w;
  endfunction

  // Exact sum over the window, divided and truncated
  function automatic logic [DATA_W-1:0] window_mean(window_t w);
    logic [63:0] acc;
    acc = '0;
    for (int i = 0; i < WINDOW; i++) acc += 64'(w[i]);
    return DATA_W'(acc / 64'(WINDOW));
  endfunction

  // Update the model for one accepted event and queue the averages it yields
  task automatic track_edge_event(input logic rise, input logic fall,
                                  input logic [DATA_W-1:0] stamp);
    averages_t avg;
    if (rise) begin
      if (model_rise_seen) model_periods = push_sample(model_periods, stamp - model_last_rise);
      model_last_rise = stamp;
      model_rise_seen = 1'b1;
    end
    if (fall && model_rise_seen)
      model_on_times = push_sample(model_on_times, stamp - model_last_rise);
    avg.period  = window_mean(model_periods);
    avg.on_time = window_mean(model_on_times);
    pending_averages.push_back(avg);
  endtask

  // Offer one request, wait for its handshake, then maybe idle
  task automatic send_event(input logic rise, input logic fall,
                            input logic [DATA_W-1:0] stamp);
    logic [USER_W-1:0] user;
    int gap;
    user            = '0;
    user[USER_RISE] = rise;
    user[USER_FALL] = fall;
    in_tdata  <= stamp;
    in_tuser  <= user;
    in_tvalid <= 1'b1;
    do @(posedge clk); while (!in_tready);
    track_edge_event(rise, fall, stamp);
    events_sent++;
    gap = ($urandom_range(0, 99) < send_gap_pct) ? idle_length() : 0;
    if (gap != 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Hold the input until every pending result is out
  task automatic wait_for_drain();
    in_tvalid <= 1'b0;
    while (pending_averages.size() != 0) @(posedge clk);
  endtask

  task automatic report_mismatch(input string what, input logic [DATA_W-1:0] got,
                                 input logic [DATA_W-1:0] want);
    $display("%0t: mismatch on %s: got %h, want %h", $time, what, got, want);
    err_count++;
  endtask

  // Span between edges, spread over several scales
  function automatic logic [DATA_W-1:0] pick_span();
    case ($urandom_range(0, 3))
      0:       return $urandom_range(0, 15);
      1:       return $urandom_range(16, 5000);
      2:       return $urandom_range(5001, 1 << 24);
      default: return $urandom;
    endcase
  endfunction

  // Well-formed pulse trains with random timing, some stray events mixed in
  task automatic run_pulse_trains(input int n_events);
    logic [DATA_W-1:0] t;
    logic [DATA_W-1:0] period;
    logic [DATA_W-1:0] on_span;
    int start;
    start  = events_sent;
    t      = ($urandom_range(0, 3) == 0) ? 32'hFFFF_FFFF - $urandom_range(0, 20000) : $urandom;
    period = pick_span();
    while (events_sent - start < n_events) begin
      if ($urandom_range(0, 9) == 0) period = pick_span();
      if ($urandom_range(0, 19) == 0) begin
        send_event(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), $urandom);
      end else begin
        on_span = (period == 0) ? '0 : $urandom_range(0, period);
        if (on_span == 0) begin
          send_event(1'b1, 1'b1, t);
        end else begin
          send_event(1'b1, 1'b0, t);
          if ($urandom_range(0, 9) == 0) send_event(1'b0, 1'b0, t + $urandom_range(0, on_span));
          send_event(1'b0, 1'b1, t + on_span);
        end
        t += period;
      end
    end
  endtask

  // Edge cases: fall before rise, first rise, wrap, shared edge, full-scale windows
  task automatic test_directed();
    logic [DATA_W-1:0] stamp;
    send_event(1'b0, 1'b1, 32'h0000_0100);
    send_event(1'b0, 1'b0, 32'h0000_0000);
    send_event(1'b1, 1'b0, 32'hFFFF_FFF0);
    send_event(1'b0, 1'b1, 32'h0000_0010);
    send_event(1'b1, 1'b0, 32'h0000_0005);
    send_event(1'b1, 1'b1, 32'h0000_1000);
    send_event(1'b0, 1'b0, 32'hFFFF_FFFF);
    // Fill the period window with full-scale periods
    stamp = 32'h0000_1000;
    for (int i = 0; i < WINDOW; i++) begin
      stamp = stamp - 1;
      send_event(1'b1, 1'b0, stamp);
    end
    // Fill the on-time window with full-scale on-times
    for (int i = 0; i < WINDOW; i++) send_event(1'b0, 1'b1, stamp - 1);
    send_event(1'b1, 1'b0, stamp);
    send_event(1'b0, 1'b0, 32'h5A5A_A5A5);
    send_event(1'b1, 1'b1, 32'hFFFF_FFFF);
    send_event(1'b0, 1'b1, 32'h0000_0000);
  endtask

  task automatic test_pulse_trains();
    send_gap_pct   = 30;
    sink_stall_pct = 30;
    run_pulse_trains(450);
  endtask

  // Random flags and stamps with no pulse structure
  task automatic test_noise();
    send_gap_pct   = 20;
    sink_stall_pct = 20;
    for (int i = 0; i < 100; i++)
      send_event(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), $urandom);
  endtask

  // Back-to-back requests against a busy sink to fill the pipeline
  task automatic test_backpressure();
    send_gap_pct   = 0;
    sink_stall_pct = 60;
    run_pulse_trains(100);
  endtask

  // Full rate on both sides
  task automatic test_full_rate();
    send_gap_pct   = 0;
    sink_stall_pct = 0;
    run_pulse_trains(80);
  endtask

  // Result sink with random stalls
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else if (stall_left != 0) begin
      out_tready <= 1'b0;
      stall_left <= stall_left - 1;
    end else if ($urandom_range(0, 99) < sink_stall_pct) begin
      out_tready <= 1'b0;
      stall_left <= idle_length();
    end else begin
      out_tready <= 1'b1;
    end
  end

  // Compare each result with the oldest pending prediction
  always @(posedge clk) begin : check_results
    averages_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_averages.size() == 0) begin
        report_mismatch("result with nothing pending", out_tdata[DATA_W-1:0], '0);
      end else begin
        want = pending_averages.pop_front();
        if (out_tdata[DATA_W-1:0] !== want.period)
          report_mismatch("average_period", out_tdata[DATA_W-1:0], want.period);
        if (out_tdata[OUT_DATA_W-1:DATA_W] !== want.on_time)
          report_mismatch("average_on_time", out_tdata[OUT_DATA_W-1:DATA_W], want.on_time);
        results_checked++;
      end
    end
  end

  // End the run if nothing moves for too long
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("%0t: timeout, %0d results still pending", $time, pending_averages.size());
      $display("pulse_period_ontime_averager_test: done, errors");
      $finish;
    end
  end

  initial begin
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    test_directed();
    wait_for_drain();
    test_pulse_trains();
    wait_for_drain();
    test_noise();
    test_backpressure();
    wait_for_drain();
    test_full_rate();
    wait_for_drain();
    repeat (TAIL_WAIT) @(posedge clk);
    $display("Sent %0d edge events, checked %0d averaged results", events_sent, results_checked);
    $display("Covered wrap, shared edges, full-scale windows, noise and back-pressure");
    if (err_count == 0) begin
      $display("pulse_period_ontime_averager_test: done, clean");
    end else begin
      $display("pulse_period_ontime_averager_test: done, errors");
    end
    $finish;
  end

endmodule

/* pulse_period_ontime_averager.f */
hw/rtl/ppoa_pkg.sv
hw/rtl/ppoa_cell.sv
hw/rtl/ppoa_window.sv
hw/rtl/ppoa_div.sv
hw/rtl/pulse_period_ontime_averager.sv
tb/pulse_period_ontime_averager_test.sv
